FILE: src/irrf_pkg.sv
// Package for the IR range filter with speed map.
// Holds widths, filter constants, controller states and the command/status structs.
// No dependencies.
package irrf_pkg;

    // Field and state widths
    localparam int DIST_W  = 9;
    localparam int SPEED_W = 8;
    localparam int CNT_W   = 4;
    localparam int SUM_W   = 13;
    localparam int PROD_W  = DIST_W + 5;
    localparam int STEP_W  = $clog2(SUM_W);
    localparam int ADDR_W  = 2;
    localparam int DATA_W  = 32;

    // Window length in samples (1 to 15)
    localparam int WINDOW_LEN = 10;

    // Filter and speed-map constants
    localparam int PREV_RESET = 20;
    localparam int RANGE_LO   = 20;
    localparam int RANGE_HI   = 81;
    localparam int SPEED_OFS  = 40;

    // Register byte addresses
    localparam logic [ADDR_W-1:0] ADDR_SENSOR_ENABLE = ADDR_W'(0);

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_LOAD
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic sample_load;
        logic div_start;
        logic div_step;
        logic out_load;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        logic win_end;
        logic div_last;
        logic out_free;
    } t_dp_stat;

endpackage

FILE: src/ir_range_filter_speed_map.sv
// Top level of the IR range filter with speed map.
// Holds the APB register and joins irrf_ctrl and irrf_dp; uses irrf_pkg.
//
//   channel   direction  handshake                 payload
//   input     in         i_in_valid / o_in_stall   i_sample_distance
//   output    out        o_out_valid / i_out_stall o_avg_distance, o_motor_speed, o_in_range
//   config    in         APB psel/penable/pwrite   paddr, pwdata, prdata
//
// An item that does not close a window leaves the controller idle and ready for the next
// item. The last item of a window is followed by states to start the divider, to run
// the restoring divider (one quotient bit a cycle), and to load the output register.
// Reset is synchronous and active low; it enables the sensor and clears the window.
// A result waiting in the output register does not block new items; only the load
// of the next window result waits for the output register to empty.
module ir_range_filter_speed_map
    import irrf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [DIST_W-1:0]  i_sample_distance,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [DIST_W-1:0]  o_avg_distance,
    output logic [SPEED_W-1:0] o_motor_speed,
    output logic               o_in_range,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

    logic     r_enable;
    t_dp_cmd  cmd;
    t_dp_stat stat;

    // Sensor enable register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
        end else if (psel && penable && pwrite && paddr == ADDR_SENSOR_ENABLE) begin
            r_enable <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_SENSOR_ENABLE) ? {{(DATA_W-1){1'b0}}, r_enable} : '0;

    irrf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_enable   (r_enable),
        .i_stat     (stat),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    irrf_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_sample_distance (i_sample_distance),
        .i_out_stall       (i_out_stall),
        .o_stat            (stat),
        .o_out_valid       (o_out_valid),
        .o_avg_distance    (o_avg_distance),
        .o_motor_speed     (o_motor_speed),
        .o_in_range        (o_in_range)
    );

endmodule

FILE: src/irrf_ctrl.sv
// Controller state machine for the IR range filter.
// Sequences sample update, window division and result load; uses irrf_pkg.
module irrf_ctrl
    import irrf_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_enable,
    input  t_dp_stat i_stat,
    output logic     o_in_stall,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_in_stall = 1'b1;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                // drop the item while disabled, else fold it into the window
                if (i_in_valid && i_enable) begin
                    o_cmd.sample_load = 1'b1;
                    if (i_stat.win_end) begin
                        n_state = ST_START;
                    end
                end
            end
            ST_START: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                // wait until the output register can take the result
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: src/irrf_dp.sv
// Datapath for the IR range filter: sample filter, window accumulators,
// restoring divider and output register. Uses irrf_pkg.
module irrf_dp
    import irrf_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic [DIST_W-1:0]  i_sample_distance,
    input  logic               i_out_stall,
    output t_dp_stat           o_stat,
    output logic               o_out_valid,
    output logic [DIST_W-1:0]  o_avg_distance,
    output logic [SPEED_W-1:0] o_motor_speed,
    output logic               o_in_range
);

    logic [DIST_W-1:0]  r_prev;
    logic [CNT_W-1:0]   r_pos;
    logic [CNT_W-1:0]   r_cnt;
    logic [SUM_W-1:0]   r_sum;
    logic [CNT_W-1:0]   r_dvs;
    logic [CNT_W-1:0]   r_rem;
    logic [SUM_W-1:0]   r_quo;
    logic [STEP_W-1:0]  r_step;
    logic               r_out_valid;
    logic [DIST_W-1:0]  r_avg;
    logic [SPEED_W-1:0] r_speed;
    logic               r_inr;

    logic [DIST_W-1:0]  diff;
    logic [PROD_W-1:0]  diff_x20;
    logic               accept;
    logic [CNT_W:0]     rem_sh;
    logic               rem_ge;
    logic [DIST_W-1:0]  avg;
    logic               inr;
    logic [DIST_W+1:0]  avg_x3;
    logic [SPEED_W-1:0] speed;

    // Accept test: 20 * |s - prev| < prev
    assign diff     = (i_sample_distance > r_prev) ? (i_sample_distance - r_prev)
                                                   : (r_prev - i_sample_distance);
    assign diff_x20 = (PROD_W'(diff) << 4) + (PROD_W'(diff) << 2);
    assign accept   = diff_x20 < PROD_W'(r_prev);

    // Filter state and window accumulators
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= DIST_W'(PREV_RESET);
            r_pos  <= '0;
            r_cnt  <= '0;
            r_sum  <= '0;
        end else if (i_cmd.sample_load) begin
            r_prev <= i_sample_distance;
            r_pos  <= o_stat.win_end ? '0 : r_pos + CNT_W'(1);
            if (accept) begin
                r_sum <= r_sum + SUM_W'(i_sample_distance);
                r_cnt <= r_cnt + CNT_W'(1);
            end
        end else if (i_cmd.div_start) begin
            r_sum <= '0;
            r_cnt <= '0;
        end
    end

    // Restoring divider step: one quotient bit per cycle
    assign rem_sh = {r_rem, r_quo[SUM_W-1]};
    assign rem_ge = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_quo  <= r_sum;
            r_dvs  <= r_cnt;
            r_rem  <= '0;
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            r_rem  <= rem_ge ? CNT_W'(rem_sh - {1'b0, r_dvs}) : CNT_W'(rem_sh);
            r_quo  <= {r_quo[SUM_W-2:0], rem_ge};
            r_step <= r_step + STEP_W'(1);
        end
    end

    // Speed map on the finished quotient; no accepted sample gives zero
    assign avg    = (r_dvs == '0) ? '0 : r_quo[DIST_W-1:0];
    assign inr    = (avg > DIST_W'(RANGE_LO)) && (avg < DIST_W'(RANGE_HI));
    assign avg_x3 = {2'b00, avg} + {1'b0, avg, 1'b0};
    assign speed  = inr ? SPEED_W'(avg_x3 - (DIST_W+2)'(SPEED_OFS)) : '0;

    // Output register: set on load, clear when the item is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_avg   <= avg;
            r_speed <= speed;
            r_inr   <= inr;
        end
    end

    // Status
    assign o_stat.win_end  = r_pos == CNT_W'(WINDOW_LEN - 1);
    assign o_stat.div_last = r_step == STEP_W'(SUM_W - 1);
    assign o_stat.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid    = r_out_valid;
    assign o_avg_distance = r_avg;
    assign o_motor_speed  = r_speed;
    assign o_in_range     = r_inr;

endmodule

FILE: src/irrf_chk.sv
// Port-level checker for the IR range filter, bound to the top level.
// Uses irrf_pkg for widths and range constants.
module irrf_chk
    import irrf_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic [DIST_W-1:0]  i_sample_distance,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic [DIST_W-1:0]  o_avg_distance,
    input logic [SPEED_W-1:0] o_motor_speed,
    input logic               o_in_range,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [ADDR_W-1:0]  paddr,
    input logic [DATA_W-1:0]  pwdata,
    input logic [DATA_W-1:0]  prdata,
    input logic               pready
);

    // Reset empties the output register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_avg_distance)
            && $stable(o_motor_speed) && $stable(o_in_range))
        else $error("stalled result changed");

    // In-range flag matches the average
    a_range_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_range == (o_avg_distance > DIST_W'(RANGE_LO)
            && o_avg_distance < DIST_W'(RANGE_HI)))
        else $error("in_range disagrees with average");

    // Speed follows the map in range
    a_speed_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_in_range |-> {3'b000, o_motor_speed}
            == ({2'b00, o_avg_distance} * 11'd3 - 11'd40))
        else $error("speed map wrong in range");

    // Speed is zero out of range
    a_speed_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_in_range |-> o_motor_speed == '0)
        else $error("speed nonzero out of range");

endmodule

bind ir_range_filter_speed_map irrf_chk u_irrf_chk (.*);

FILE: tb/tb_ir_range_filter_speed_map.sv
// Testbench for the IR range filter with speed map: directed windows, then random phases.
// Tracks window state in its own predictor and checks every result item; uses irrf_pkg.
`timescale 1ns / 1ps

module tb_ir_range_filter_speed_map
    import irrf_pkg::*;
();

    localparam int NUM_ITEMS   = 1400;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 24;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_PRINTS  = 40;

    typedef struct {
        logic [DIST_W-1:0]  avg;
        logic [SPEED_W-1:0] speed;
        logic               in_range;
    } t_window_result;

    // DUT connections; the inputs are driven to known values from time zero
    logic               i_clk             = 1'b0;
    logic               i_rst_n           = 1'b0;
    logic               i_in_valid        = 1'b0;
    logic               o_in_stall;
    logic [DIST_W-1:0]  i_sample_distance = '0;
    logic               o_out_valid;
    logic               i_out_stall       = 1'b0;
    logic [DIST_W-1:0]  o_avg_distance;
    logic [SPEED_W-1:0] o_motor_speed;
    logic               o_in_range;
    logic               psel              = 1'b0;
    logic               penable           = 1'b0;
    logic               pwrite            = 1'b0;
    logic [ADDR_W-1:0]  paddr             = '0;
    logic [DATA_W-1:0]  pwdata            = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    // Predicted window state
    logic               sensor_on  = 1'b1;
    logic [DIST_W-1:0]  prev_dist  = DIST_W'(PREV_RESET);
    logic [CNT_W-1:0]   win_pos    = '0;
    logic [CNT_W-1:0]   acc_cnt    = '0;
    logic [SUM_W-1:0]   acc_sum    = '0;

    logic [DIST_W-1:0]  sample_queue[$];
    t_window_result     window_results[$];

    int err_count   = 0;
    int cycle_count = 0;
    int gap_mode    = 0;
    int stall_mode  = 0;
    int hold_req    = 0;
    int hold_ack    = 0;
    int hold_left   = 0;
    int gen_last    = PREV_RESET;
    int driver_idle = 0;

    ir_range_filter_speed_map u_top (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_sample_distance (i_sample_distance),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_avg_distance    (o_avg_distance),
        .o_motor_speed     (o_motor_speed),
        .o_in_range        (o_in_range),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    // 12 ns clock
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        if (err_count < MAX_PRINTS)
            $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want,
                     cycle_count);
        err_count++;
    endtask

    // Apply one accepted sample to the window state; queue a result at window end
    function automatic void take_sample(input logic [DIST_W-1:0] sample_dist);
        int             diff;
        int             avg;
        t_window_result res;
        if (!sensor_on)
            return;
        diff = (sample_dist > prev_dist) ? int'(sample_dist) - int'(prev_dist)
                                         : int'(prev_dist) - int'(sample_dist);
        if (20 * diff < int'(prev_dist)) begin
            acc_sum = acc_sum + SUM_W'(sample_dist);
            acc_cnt = acc_cnt + CNT_W'(1);
        end
        prev_dist = sample_dist;
        win_pos   = win_pos + CNT_W'(1);
        if (int'(win_pos) < WINDOW_LEN)
            return;
        avg = (acc_cnt != 0) ? int'(acc_sum) / int'(acc_cnt) : 0;
        res.avg      = DIST_W'(avg);
        res.in_range = (res.avg > RANGE_LO) && (res.avg < RANGE_HI);
        res.speed    = res.in_range ? SPEED_W'(3 * int'(res.avg) - SPEED_OFS) : '0;
        window_results.push_back(res);
        win_pos = '0;
        acc_cnt = '0;
        acc_sum = '0;
    endfunction

    // Mode 1: mostly no or short gaps, a few long ones; mode 0 gives no gaps
    function automatic int draw_idle(input int mode);
        int r;
        r = $urandom_range(0, 99);
        if (mode == 0 || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random walk that mostly stays within the acceptance band, with jumps and noise
    function automatic logic [DIST_W-1:0] next_distance();
        int r;
        int step;
        int v;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            step = $urandom_range(0, gen_last / 21);
            v = $urandom_range(0, 1) ? gen_last + step : gen_last - step;
        end else if (r < 75) begin
            v = gen_last;
        end else if (r < 90) begin
            v = $urandom_range(0, 1) ? $urandom_range(15, 90) : $urandom_range(0, 511);
        end else begin
            v = $urandom_range(0, 511);
        end
        if (v < 0)
            v = 0;
        if (v > 511)
            v = 511;
        gen_last = v;
        return DIST_W'(v);
    endfunction

    // Cycle counter and timeout
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Driver: offer queued samples with random gaps; hold payload while stalled
    always @(posedge i_clk) begin : driver
        int  idle;
        logic fire;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            fire = i_in_valid && !o_in_stall;
            if (fire)
                take_sample(i_sample_distance);
            if (!i_in_valid || fire) begin
                idle = fire ? draw_idle(gap_mode) : driver_idle;
                if (idle != 0) begin
                    i_in_valid  <= 1'b0;
                    driver_idle = idle - 1;
                end else if (sample_queue.size() != 0) begin
                    i_in_valid        <= 1'b1;
                    i_sample_distance <= sample_queue.pop_front();
                    driver_idle = 0;
                end else begin
                    i_in_valid  <= 1'b0;
                    driver_idle = 0;
                end
            end
        end
    end

    // Long receiver hold-off, counted here
    always @(posedge i_clk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: check each result item, then choose the next stall
    always @(posedge i_clk) begin : monitor
        t_window_result want;
        int             stall_left;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (window_results.size() == 0) begin
                    report_mismatch("unexpected result, avg_distance", o_avg_distance, -1);
                end else begin
                    want = window_results.pop_front();
                    if (o_avg_distance !== want.avg)
                        report_mismatch("avg_distance", o_avg_distance, want.avg);
                    if (o_motor_speed !== want.speed)
                        report_mismatch("motor_speed", o_motor_speed, want.speed);
                    if (o_in_range !== want.in_range)
                        report_mismatch("in_range", o_in_range, want.in_range);
                end
            end
            if (stall_left != 0)
                stall_left--;
            else
                stall_left = draw_idle(stall_mode);
            i_out_stall <= (hold_left != 0) || (hold_req != hold_ack) || (stall_left != 0);
        end
    end

    // Register write: setup cycle, then access cycle until pready
    task automatic reg_write(input logic [DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_SENSOR_ENABLE;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sensor_on = value[0];
    endtask

    // Register read and compare with the predicted enable
    task automatic reg_check();
        logic [DATA_W-1:0] got;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_SENSOR_ENABLE;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        got = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        if (got !== DATA_W'(sensor_on))
            report_mismatch("sensor_enable readback", got, sensor_on);
    endtask

    // Wait until every item is sent and every result has come, then settle
    task automatic drain();
        @(negedge i_clk);
        while (sample_queue.size() != 0 || i_in_valid || window_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic push_samples(input int count);
        repeat (count) sample_queue.push_back(next_distance());
    endtask

    // Stimulus sequence
    initial begin : stimulus
        int phase;
        int count;
        int sent;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        reg_check();

        // Window with no accepted sample: extremes, jumps, and a zero previous sample
        sample_queue = '{9'd0, 9'd0, 9'd511, 9'd0, 9'd256, 9'd0, 9'd1, 9'd0, 9'd511, 9'd0};
        drain();

        // Window split by a disabled stretch; dropped samples must not touch the state
        sample_queue = '{9'd81, 9'd80, 9'd80, 9'd80};
        drain();
        reg_write(32'hFFFF_FFFE);
        reg_check();
        sample_queue = '{9'd300, 9'd5, 9'd0};
        drain();
        reg_write(32'hFFFF_FFFF);
        reg_check();
        sample_queue = '{9'd80, 9'd80, 9'd80, 9'd80, 9'd80, 9'd79};
        drain();
        gen_last = 79;

        // Random phases with rotating idle patterns
        sent  = 0;
        phase = 0;
        while (sent < NUM_ITEMS) begin
            phase++;
            gap_mode   = (phase % 4 == 0 || phase % 4 == 3) ? 1 : 0;
            stall_mode = (phase % 4 == 0 || phase % 4 == 2) ? 1 : 0;
            if (phase % 5 == 4) begin
                reg_write($urandom() & ~32'd1);
                reg_check();
                push_samples($urandom_range(5, 20));
                drain();
                reg_write($urandom() | 32'd1);
                reg_check();
            end
            count = $urandom_range(40, 200);
            if (phase % 4 == 2) begin
                // Hold the receiver while samples keep coming
                count = $urandom_range(60, 200);
                @(negedge i_clk);
                hold_req++;
            end
            push_samples(count);
            sent += count;
            drain();
        end

        if (window_results.size() != 0)
            report_mismatch("results left over", window_results.size(), 0);
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
